[src/circular_deque_top_macros.svh]
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Shorthand for the concurrent checks used in the deque RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_TOP_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CDQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CDQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CDQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and fixed widths shared by the circular deque RTL.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   typedef enum logic [OP_W-1:0] {
      OP_INS_REAR  = 3'd0,
      OP_REM_REAR  = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_INS_FRONT = 3'd3,
      OP_RD_FRONT  = 3'd4,
      OP_RD_REAR   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Result held while the store read completes.
   typedef struct packed {
      status_type       status;
      logic [CAP_W-1:0] occupancy;
      logic             use_mem;
   } pend_type;

endpackage

[src/cdq_if.sv]
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels of the circular deque: request, response and CSR.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   import cdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, op, data_in, input ready);
   modport sink   (input valid, op, data_in, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data_out;
   logic [CAP_W-1:0]         occupancy;

   modport source (output valid, status, data_out, occupancy, input ready);
   modport sink   (input valid, status, data_out, occupancy, output ready);
endinterface

interface cdq_csr_if;
   import cdq_pkg::*;

   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

[src/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/circular_deque_top.sv]
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of signed 32-bit words in a circular slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one request per handshake: op (insert rear/front, remove
//             rear/front, read front/rear) and data_in for inserts.
//   rsp_ch  : one response per request, in order: status (done, full,
//             empty), data_out (removed or read word, else zero) and the
//             occupancy after the operation.
//   csr_ch  : writes capacity_in_use (0 acts as 1, above DEPTH acts as
//             DEPTH). A write empties the deque; slot contents are kept.
//             Write only while no request is in flight.
// Throughput is one request per cycle while the receiver keeps up: head,
// tail and count update at acceptance, and each request makes at most one
// read or write on the slot memory. A response passes through the
// registered memory read and pending stage, then the response register.
// Reset empties the deque and sets the capacity to 16. Slots read nothing
// defined until written; only occupied slots are ever read.
// When the receiver stalls, the response register holds, the pending stage
// behind it fills, and req_ch.ready drops until the pending result moves.
// ----------------------------------------------------------------------------
`include "circular_deque_top_macros.svh"

module circular_deque_top #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   cdq_req_if.sink  req_ch,
   cdq_rsp_if.source rsp_ch,
   cdq_csr_if.sink  csr_ch
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

   logic [CAP_W-1:0]  cap_ff, cap_in, cap_eff;
   logic [IDX_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CAP_W-1:0]  count_ff, count_in;
   logic              pend_valid_ff, pend_valid_in;
   pend_type          pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CAP_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic              req_fire, csr_fire, pend_move;
   op_type            op;
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;

   // Wrap an index forward or back within the effective capacity.
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt >= CW'(cap)) ? '0 : nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
      logic [CW-1:0] top;
      top = CW'(cap) - CW'(1);
      return (idx == '0) ? top[IDX_W-1:0] : idx - IDX_W'(1);
   endfunction

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign op        = op_type'(req_ch.op);
   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pend_valid_ff || pend_move;
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire  = csr_ch.valid;

   assign head_inc = wrap_inc(head_ff, cap_eff);
   assign head_dec = wrap_dec(head_ff, cap_eff);
   assign tail_inc = wrap_inc(tail_ff, cap_eff);
   assign tail_dec = wrap_dec(tail_ff, cap_eff);

   // Request decode: index/count update and at most one memory access.
   always_comb begin
      logic [IDX_W-1:0] h, t;
      logic [CAP_W-1:0] c;
      logic             do_wr, do_rd;
      logic [IDX_W-1:0] wa, ra;
      status_type       st;

      h     = head_ff;
      t     = tail_ff;
      c     = count_ff;
      do_wr = 1'b0;
      do_rd = 1'b0;
      wa    = '0;
      ra    = head_ff;
      st    = ST_DONE;

      case (op)
         OP_INS_REAR, OP_INS_FRONT: begin
            if (count_ff >= cap_eff) begin
               st = ST_FULL;
            end else begin
               do_wr = 1'b1;
               c     = count_ff + CAP_W'(1);
               if (count_ff == '0) begin
                  h  = '0;
                  t  = '0;
                  wa = '0;
               end else if (op == OP_INS_REAR) begin
                  t  = tail_inc;
                  wa = tail_inc;
               end else begin
                  h  = head_dec;
                  wa = head_dec;
               end
            end
         end
         OP_REM_REAR, OP_REM_FRONT: begin
            if (count_ff == '0) begin
               st = ST_EMPTY;
            end else begin
               do_rd = 1'b1;
               ra    = (op == OP_REM_REAR) ? tail_ff : head_ff;
               c     = count_ff - CAP_W'(1);
               if (count_ff == CAP_W'(1)) begin
                  h = '0;
                  t = '0;
               end else if (op == OP_REM_REAR) begin
                  t = tail_dec;
               end else begin
                  h = head_inc;
               end
            end
         end
         OP_RD_FRONT, OP_RD_REAR: begin
            if (count_ff == '0) begin
               st = ST_EMPTY;
            end else begin
               do_rd = 1'b1;
               ra    = (op == OP_RD_FRONT) ? head_ff : tail_ff;
            end
         end
         default: begin
            st = ST_DONE;
         end
      endcase

      wr_en   = req_fire && do_wr;
      rd_en   = req_fire && do_rd;
      wr_addr = wa;
      rd_addr = ra;

      cap_in   = cap_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (csr_fire) begin
         // A capacity write empties the deque.
         cap_in   = csr_ch.wdata;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (req_fire) begin
         head_in  = h;
         tail_in  = t;
         count_in = c;
      end

      pend_in.status    = st;
      pend_in.occupancy = c;
      pend_in.use_mem   = do_rd;
   end

   // Pending stage and response register.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_fire) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (pend_move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_ff.status;
         rsp_data_in   = pend_ff.use_mem ? rd_data : '0;
         rsp_occ_in    = pend_ff.occupancy;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_W'(CAP_RESET);
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_ff <= pend_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.data_out  = $signed(rsp_data_ff);
   assign rsp_ch.occupancy = rsp_occ_ff;

   `CDQ_ASSERT_ALWAYS(a_count_le_cap, clock, reset, count_ff <= cap_eff, "count above capacity")
   `CDQ_ASSERT_ALWAYS(a_idx_in_cap, clock, reset,
      (CW'(head_ff) < CW'(cap_eff)) && (CW'(tail_ff) < CW'(cap_eff)), "index beyond capacity")
   `CDQ_ASSERT_IMP(a_empty_idx, clock, reset, count_ff == '0,
      (head_ff == '0) && (tail_ff == '0), "empty deque with nonzero index")
   `CDQ_ASSERT_NXT(a_pend_hold, clock, reset, pend_valid_ff && !pend_move,
      pend_valid_ff && $stable(pend_ff) && $stable(rd_data), "stalled pending result changed")

endmodule

[tb/tb_circular_deque_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque_top
// Drives insert, remove and read requests into the deque under several
// capacities and idle patterns. A scoreboard tracks the expected deque
// contents and checks every response, field by field, in order.
// ----------------------------------------------------------------------------
module tb_circular_deque_top;
   import cdq_pkg::*;

   localparam int DEPTH      = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES     = 8;
   localparam int PHASE_REQS = 215;

   // Op codes outside the defined set; the deque must ignore them.
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic [CAP_W-1:0]         occupancy;
   } deque_result_type;

   class deque_scoreboard;
      logic signed [DATA_W-1:0] slots [DEPTH];
      logic [CAP_W-1:0]         capacity;
      int                       head;
      int                       tail;
      int                       count;
      int                       failures;
      deque_result_type         pending_results [$];

      function new();
         foreach (slots[i]) slots[i] = '0;
         capacity = CAP_W'(CAP_RESET);
         head     = 0;
         tail     = 0;
         count    = 0;
         failures = 0;
      endfunction

      function int effective_capacity();
         if (capacity == 0) return 1;
         if (capacity > DEPTH) return DEPTH;
         return capacity;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function int wrap_next(int idx, int cap);
         return (idx + 1 >= cap) ? 0 : idx + 1;
      endfunction

      function int wrap_prev(int idx, int cap);
         return (idx == 0) ? cap - 1 : idx - 1;
      endfunction

      // A capacity write empties the deque but keeps the slot contents.
      function void apply_capacity(logic [CAP_W-1:0] value);
         capacity = value;
         head     = 0;
         tail     = 0;
         count    = 0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
         int               cap;
         deque_result_type res;
         cap        = effective_capacity();
         res.status = ST_DONE;
         res.data   = '0;
         case (op)
            OP_INS_REAR, OP_INS_FRONT: begin
               if (count >= cap) begin
                  res.status = ST_FULL;
               end else if (count == 0) begin
                  head     = 0;
                  tail     = 0;
                  slots[0] = value;
                  count    = 1;
               end else if (op == OP_INS_REAR) begin
                  tail        = wrap_next(tail, cap);
                  slots[tail] = value;
                  count++;
               end else begin
                  head        = wrap_prev(head, cap);
                  slots[head] = value;
                  count++;
               end
            end
            OP_REM_REAR, OP_REM_FRONT: begin
               if (count == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.data = (op == OP_REM_REAR) ? slots[tail] : slots[head];
                  if (count == 1) begin
                     head = 0;
                     tail = 0;
                  end else if (op == OP_REM_REAR) begin
                     tail = wrap_prev(tail, cap);
                  end else begin
                     head = wrap_next(head, cap);
                  end
                  count--;
               end
            end
            OP_RD_FRONT, OP_RD_REAR: begin
               if (count == 0) res.status = ST_EMPTY;
               else res.data = (op == OP_RD_FRONT) ? slots[head] : slots[tail];
            end
            default: ;
         endcase
         res.occupancy = CAP_W'(count);
         pending_results.push_back(res);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic signed [DATA_W-1:0] data,
                                   logic [CAP_W-1:0] occupancy);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: status %0d data %0d occupancy %0d",
                        status, data, occupancy);
            return;
         end
         want = pending_results.pop_front();
         if (status !== want.status || data !== want.data || occupancy !== want.occupancy)
         begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected status %0d data %0d occupancy %0d, got %0d %0d %0d",
                        want.status, want.data, want.occupancy, status, data, occupancy);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();
   cdq_csr_if csr_ch ();

   circular_deque_top #(.DEPTH(DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   deque_scoreboard sb = new();
   int              idle_pct  = 0;
   int              stall_pct = 0;
   bit              grow      = 1'b1;
   int              quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Check responses and end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.data_out, rsp_ch.occupancy);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.data_in <= value;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, value);
   endtask

   // Hold off new requests until every response has come back.
   task automatic drain_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_requests();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.apply_capacity(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int r;
      bit toward_full;
      r = $urandom_range(0, 99);
      if (r < 4) return $urandom_range(0, 1) ? OP_UNDEF_LO : OP_UNDEF_HI;
      if (r < 24) return $urandom_range(0, 1) ? OP_RD_FRONT : OP_RD_REAR;
      toward_full = (r < 78) ? grow : !grow;
      if (toward_full) return $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
      return $urandom_range(0, 1) ? OP_REM_REAR : OP_REM_FRONT;
   endfunction

   // Swing the deque between empty and full so both ends wrap and reject.
   task automatic run_phase(input int target);
      int               accepted;
      logic [OP_W-1:0]  op;
      accepted = 0;
      while (accepted < target) begin
         if (sb.count == 0 && $urandom_range(0, 1)) grow = 1'b1;
         else if (sb.count >= sb.effective_capacity() && $urandom_range(0, 1)) grow = 1'b0;
         op = pick_op();
         send_request(op, random_word());
         if (op <= OP_RD_REAR) accepted++;
      end
   endtask

   initial begin
      logic [CAP_W-1:0] phase_caps [PHASES];
      phase_caps = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd17, 5'd0, 5'd9, 5'd16};
      phase_caps[6] = CAP_W'($urandom_range(3, 15));

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_INS_REAR;
      req_ch.data_in = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.wdata   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty deque: every removal and read is rejected, undefined ops pass.
      send_request(OP_RD_FRONT, 32'sd5);
      send_request(OP_RD_REAR, 32'sd5);
      send_request(OP_REM_REAR, 32'sd5);
      send_request(OP_REM_FRONT, 32'sd5);
      send_request(OP_UNDEF_LO, 32'sd7);
      send_request(OP_UNDEF_HI, -32'sd1);
      // First insert lands in slot zero, then grow both ends past the wrap.
      send_request(OP_INS_REAR, 32'sh7FFF_FFFF);
      send_request(OP_INS_FRONT, 32'sh8000_0000);
      send_request(OP_INS_REAR, -32'sd1);
      send_request(OP_INS_FRONT, '0);
      send_request(OP_RD_FRONT, '0);
      send_request(OP_RD_REAR, '0);
      send_request(OP_REM_FRONT, '0);
      send_request(OP_REM_REAR, '0);
      send_request(OP_REM_REAR, '0);
      send_request(OP_REM_FRONT, '0);

      // Capacity zero behaves as a single slot.
      write_capacity(5'd0);
      send_request(OP_INS_REAR, 32'sd1234);
      send_request(OP_INS_FRONT, 32'sd99);
      send_request(OP_INS_REAR, 32'sd98);
      send_request(OP_RD_REAR, '0);
      send_request(OP_REM_FRONT, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 72; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         grow = 1'b1;
         run_phase(PHASE_REQS);
      end

      drain_requests();
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
